>>> rtl/cle_pkg.sv
package cle_pkg;

    // default sizes and field widths
    localparam int LINE_MAX_DEF = 63;
    localparam int LEN_W        = 6;
    localparam int CHAR_W       = 8;
    localparam int CMD_DEPTH    = 2;
    localparam logic [LEN_W-1:0] CAP_RESET = 6'd63;

    // character codes
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_CHAR  = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    // classified operations handed from front to back
    typedef enum logic [1:0] {
        OP_PRINT = 2'd0,
        OP_ERASE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_ENTER = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_link_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BS_IDLE  = 2'd0,
        BS_FETCH = 2'd1,
        BS_EMIT  = 2'd2,
        BS_END   = 2'd3
    } back_state_t;

endpackage

>>> rtl/cooked_line_editor_unit.sv
// a result passes through the command queue and then the result register before it is on the ports
// printable, erase and escape are handled without the back end leaving idle
// enter on a non-empty line reads it out through the registered store read, a fetch and an emit per char
// the 2-entry command queue keeps taking beats while the back end is busy, until it is full
// reset: queue, line length, sequencer state and result valid cleared, capacity back to 63,
// line store contents left as they are
module cooked_line_editor_unit
    import cle_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_data,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        kind,
    output logic [CHAR_W-1:0] char_out,
    output logic [LEN_W-1:0]  erase_count,
    output logic [LEN_W-1:0]  line_length,
    output logic              last
);

    cmd_link_t cmd_link;
    logic      cmd_take;

    // classify and queue incoming beats
    cle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .char_in  (char_in),
        .full     (full),
        .cmd_link (cmd_link),
        .cmd_take (cmd_take)
    );

    // line store and result sequencing
    cle_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .cmd_link    (cmd_link),
        .cmd_take    (cmd_take),
        .pop         (pop),
        .empty       (empty),
        .kind        (kind),
        .char_out    (char_out),
        .erase_count (erase_count),
        .line_length (line_length),
        .last        (last)
    );

endmodule

>>> rtl/cle_front.sv
module cle_front
    import cle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [CHAR_W-1:0] char_in,
    output logic              full,
    output cmd_link_t         cmd_link,
    input  logic              cmd_take
);

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             q_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic is_print;
    logic is_erase;
    logic is_clear;
    logic is_enter;
    logic keep;
    logic enq;
    logic deq;
    cmd_t new_cmd;

    // classify the incoming byte, everything else is dropped here
    always_comb
    begin
        is_print = (char_in >= CH_SPACE) && (char_in < CH_DEL);
        is_erase = (char_in == CH_BS) || (char_in == CH_DEL);
        is_clear = (char_in == CH_ESC);
        is_enter = (char_in == CH_LF) || (char_in == CH_CR);
        keep     = is_print || is_erase || is_clear || is_enter;
        new_cmd.ch = char_in;
        if (is_enter)
        begin
            new_cmd.op = OP_ENTER;
        end
        else if (is_erase)
        begin
            new_cmd.op = OP_ERASE;
        end
        else if (is_clear)
        begin
            new_cmd.op = OP_CLEAR;
        end
        else
        begin
            new_cmd.op = OP_PRINT;
        end
    end

    // command queue control
    always_comb
    begin
        full        = (count_reg == CNT_W'(CMD_DEPTH));
        enq         = push && !full && keep;
        deq         = cmd_take && (count_reg != '0);
        wr_ptr_next = enq ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(enq) - CNT_W'(deq);
        cmd_link.valid = (count_reg != '0);
        cmd_link.cmd   = q_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> rtl/cle_back.sv
module cle_back
    import cle_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_data,
    input  cmd_link_t         cmd_link,
    output logic              cmd_take,
    input  logic              pop,
    output logic              empty,
    output logic [1:0]        kind,
    output logic [CHAR_W-1:0] char_out,
    output logic [LEN_W-1:0]  erase_count,
    output logic [LEN_W-1:0]  line_length,
    output logic              last
);

    localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LINE_MAX);

    logic [CHAR_W-1:0] line_mem [LINE_MAX];
    logic [CHAR_W-1:0] rd_data_reg;

    logic [LEN_W-1:0]  cap_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  rd_idx_reg;
    logic [LEN_W-1:0]  rd_idx_next;
    back_state_t       state_reg;
    back_state_t       state_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    kind_t             out_kind_reg;
    kind_t             out_kind_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic [CHAR_W-1:0] out_char_next;
    logic [LEN_W-1:0]  out_erase_reg;
    logic [LEN_W-1:0]  out_erase_next;
    logic [LEN_W-1:0]  out_len_reg;
    logic [LEN_W-1:0]  out_len_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic [LEN_W-1:0]  cap_eff;
    logic              slot_free;
    logic              load;
    logic              mem_we;
    logic              mem_re;

    // sequencer: one command per cycle while idle and the result slot is free, enter reads the line out
    always_comb
    begin
        cap_eff        = (cap_reg < MAX_LEN) ? cap_reg : MAX_LEN;
        slot_free      = !out_valid_reg || pop;
        state_next     = state_reg;
        len_next       = len_reg;
        rd_idx_next    = rd_idx_reg;
        cmd_take       = 1'b0;
        load           = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        out_kind_next  = KIND_ECHO;
        out_char_next  = '0;
        out_erase_next = '0;
        out_len_next   = '0;
        out_last_next  = 1'b1;
        case (state_reg)
            BS_IDLE:
            begin
                if (cmd_link.valid && slot_free)
                begin
                    cmd_take = 1'b1;
                    case (cmd_link.cmd.op)
                        OP_PRINT:
                        begin
                            if (len_reg < cap_eff)
                            begin
                                mem_we        = 1'b1;
                                load          = 1'b1;
                                out_kind_next = KIND_ECHO;
                                out_char_next = cmd_link.cmd.ch;
                                len_next      = len_reg + LEN_W'(1);
                            end
                        end
                        OP_ERASE:
                        begin
                            if (len_reg != '0)
                            begin
                                load           = 1'b1;
                                out_kind_next  = KIND_ERASE;
                                out_erase_next = LEN_W'(1);
                                len_next       = len_reg - LEN_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (len_reg != '0)
                            begin
                                load           = 1'b1;
                                out_kind_next  = KIND_ERASE;
                                out_erase_next = len_reg;
                                len_next       = '0;
                            end
                        end
                        OP_ENTER:
                        begin
                            if (len_reg == '0)
                            begin
                                load          = 1'b1;
                                out_kind_next = KIND_END;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                state_next  = BS_FETCH;
                            end
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            BS_FETCH:
            begin
                mem_re     = 1'b1;
                state_next = BS_EMIT;
            end
            BS_EMIT:
            begin
                if (slot_free)
                begin
                    load          = 1'b1;
                    out_kind_next = KIND_CHAR;
                    out_char_next = rd_data_reg;
                    out_last_next = 1'b0;
                    rd_idx_next   = rd_idx_reg + LEN_W'(1);
                    if (rd_idx_reg + LEN_W'(1) == len_reg)
                    begin
                        state_next = BS_END;
                    end
                    else
                    begin
                        state_next = BS_FETCH;
                    end
                end
            end
            BS_END:
            begin
                if (slot_free)
                begin
                    load          = 1'b1;
                    out_kind_next = KIND_END;
                    out_len_next  = len_reg;
                    len_next      = '0;
                    state_next    = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            len_reg       <= '0;
            rd_idx_reg    <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg  <= out_kind_next;
            out_char_reg  <= out_char_next;
            out_erase_reg <= out_erase_next;
            out_len_reg   <= out_len_next;
            out_last_reg  <= out_last_next;
        end
    end

    // line store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[len_reg[IDX_W-1:0]] <= cmd_link.cmd.ch;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign empty       = !out_valid_reg;
    assign kind        = out_kind_reg;
    assign char_out    = out_char_reg;
    assign erase_count = out_erase_reg;
    assign line_length = out_len_reg;
    assign last        = out_last_reg;

    // checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= MAX_LEN)
        else $error("line length beyond store depth");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_kind_reg)
            && $stable(out_char_reg) && $stable(out_len_reg))
        else $error("waiting result changed before pop");

    a_read_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_FETCH || state_reg == BS_EMIT) |-> rd_idx_reg < len_reg)
        else $error("line readout past stored length");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != BS_IDLE |-> !cmd_take)
        else $error("command taken during line readout");

endmodule

>>> tb/sv/cooked_line_editor_unit_test.sv
`timescale 1ns / 1ps

module cooked_line_editor_unit_test;
    import cle_pkg::*;

    // one result beat as the block presents it
    typedef struct {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  erase;
        logic [LEN_W-1:0]  length;
        logic              last;
    } out_beat_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [CHAR_W-1:0] char_in;
    logic              cfg_we;
    logic [LEN_W-1:0]  cfg_data;
    logic              empty;
    logic              pop;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  erase_count;
    logic [LEN_W-1:0]  line_length;
    logic              last;

    // shadow line state of the editor
    logic [CHAR_W-1:0] line_buf [0:LINE_MAX_DEF-1];
    logic [LEN_W-1:0]  line_cnt;
    logic [LEN_W-1:0]  line_cap;

    out_beat_t predicted_out[$];
    int        error_count;
    bit        idle_on;
    int        hold_cycles;

    cooked_line_editor_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_in     (char_in),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .char_out    (char_out),
        .erase_count (erase_count),
        .line_length (line_length),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("cooked_line_editor_unit: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < 100)
            $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void expect_beat(input kind_t k, input logic [CHAR_W-1:0] ch,
                                        input logic [LEN_W-1:0] er,
                                        input logic [LEN_W-1:0] len, input logic lst);
        out_beat_t b;
        b.kind   = k;
        b.ch     = ch;
        b.erase  = er;
        b.length = len;
        b.last   = lst;
        predicted_out.push_back(b);
    endfunction

    // line discipline: update shadow line and queue the beats one char causes
    function automatic void edit_line(input logic [CHAR_W-1:0] c);
        int i;
        if (c == CH_LF || c == CH_CR)
        begin
            for (i = 0; i < line_cnt; i++)
                expect_beat(KIND_CHAR, line_buf[i], '0, '0, 1'b0);
            expect_beat(KIND_END, '0, '0, line_cnt, 1'b1);
            line_cnt = '0;
        end
        else if (c == CH_BS || c == CH_DEL)
        begin
            if (line_cnt > 0)
            begin
                line_cnt = line_cnt - 1'b1;
                expect_beat(KIND_ERASE, '0, 6'd1, '0, 1'b1);
            end
        end
        else if (c == CH_ESC)
        begin
            if (line_cnt > 0)
            begin
                expect_beat(KIND_ERASE, '0, line_cnt, '0, 1'b1);
                line_cnt = '0;
            end
        end
        else if (c >= CH_SPACE && c < CH_DEL)
        begin
            // full line drops the char with no beat
            if (line_cnt < line_cap)
            begin
                line_buf[line_cnt] = c;
                line_cnt = line_cnt + 1'b1;
                expect_beat(KIND_ECHO, c, '0, '0, 1'b1);
            end
        end
    endfunction

    // offer one char beat, predict when it is taken
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        char_in <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        edit_line(c);
    endtask

    // stop sending until every beat is out and the back end has settled
    task automatic wait_line_idle();
        push <= 1'b0;
        while (predicted_out.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [LEN_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        line_cap = v;
        @(posedge clk);
    endtask

    // result side: check taken beats, random and forced stalls
    initial
    begin
        out_beat_t want;
        int        stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (predicted_out.size() == 0)
                    report_mismatch("beat with nothing pending, kind", kind, -1);
                else
                begin
                    want = predicted_out.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (char_out !== want.ch)
                        report_mismatch("char_out", char_out, want.ch);
                    if (erase_count !== want.erase)
                        report_mismatch("erase_count", erase_count, want.erase);
                    if (line_length !== want.length)
                        report_mismatch("line_length", line_length, want.length);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (hold_cycles > 0)
            begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic test_basic_typing();
        send_char(8'h20);
        send_char(8'h7E);
        send_char(CH_CR);
        // enter on an empty line
        send_char(CH_LF);
    endtask

    task automatic test_erase();
        // erase on an empty line gives nothing
        send_char(CH_BS);
        send_char(CH_DEL);
        send_char(CH_ESC);
        send_char("a");
        send_char("b");
        send_char(CH_BS);
        send_char(CH_DEL);
        send_char("x");
        send_char("y");
        send_char(CH_ESC);
        send_char(CH_LF);
    endtask

    task automatic test_ignored_bytes();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h1F);
        send_char(8'h09);
        send_char("k");
        send_char(CH_CR);
    endtask

    task automatic test_capacity_limits();
        int i;
        // capacity of zero stores nothing
        wait_line_idle();
        set_capacity(6'd0);
        send_char("a");
        send_char(CH_CR);
        // lowering capacity below the stored length keeps the chars
        wait_line_idle();
        set_capacity(6'd63);
        for (i = 0; i < 4; i++)
            send_char(8'(8'h30 + i));
        wait_line_idle();
        set_capacity(6'd2);
        send_char("q");
        send_char(CH_BS);
        send_char("r");
        send_char(CH_BS);
        send_char(CH_BS);
        send_char("s");
        send_char(CH_LF);
    endtask

    task automatic test_full_line_backpressure();
        int i;
        wait_line_idle();
        set_capacity(6'd63);
        // receiver holds off while a full line is typed, then a max readout
        hold_cycles = 300;
        for (i = 0; i < 66; i++)
            send_char(8'(8'h21 + i));
        send_char(CH_CR);
        wait_line_idle();
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 68)
            return 8'($urandom_range(32, 126));
        else if (r < 76)
            return ($urandom_range(0, 1) == 0) ? CH_BS : CH_DEL;
        else if (r < 80)
            return CH_ESC;
        else if (r < 90)
            return ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_random_lines();
        logic [LEN_W-1:0] caps [0:5];
        logic [CHAR_W-1:0] c;
        int p;
        int counted;
        caps[0] = 6'd1;
        caps[1] = 6'd5;
        caps[2] = 6'($urandom_range(0, 63));
        caps[3] = 6'd0;
        caps[4] = 6'd17;
        caps[5] = 6'd63;
        for (p = 0; p < 6; p++)
        begin
            wait_line_idle();
            set_capacity(caps[p]);
            // closing phase runs with no idling on either side
            if (p == 5)
                idle_on = 1'b0;
            counted = 0;
            while (counted < 7)
            begin
                c = pick_char();
                send_char(c);
                if (c == CH_CR || c == CH_LF || c == CH_BS || c == CH_DEL ||
                    c == CH_ESC || (c >= CH_SPACE && c < CH_DEL))
                    counted++;
            end
            send_char(CH_LF);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        char_in     = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        pop         = 1'b0;
        line_cnt    = '0;
        line_cap    = CAP_RESET;
        error_count = 0;
        idle_on     = 1'b1;
        hold_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_typing();
        test_erase();
        test_ignored_bytes();
        test_capacity_limits();
        test_full_line_backpressure();
        test_random_lines();

        wait_line_idle();
        if (error_count == 0)
            $display("cooked_line_editor_unit: match");
        else
            $display("cooked_line_editor_unit: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/cle_pkg.sv
rtl/cle_front.sv
rtl/cle_back.sv
rtl/cooked_line_editor_unit.sv
tb/sv/cooked_line_editor_unit_test.sv
